[design/afc_pkg.sv]
// Shared types and constants for the box-versus-frustum classifier.
package afc_pkg;

   localparam int PLANE_COUNT = 6;
   localparam int FAR_INDEX   = 4;
   localparam int NORM_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_TOP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_BOTTOM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_LEFT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_RIGHT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_FAR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_NEAR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_INFINITE = 3'd6;

   typedef enum logic [1:0] {
      VIS_NONE    = 2'd0,
      VIS_PARTIAL = 2'd1,
      VIS_FULL    = 2'd2
   } vis_type;

   // One plane register; nx sits in the lowest bits
   typedef struct packed {
      logic signed [NORM_W-1:0] d;
      logic signed [NORM_W-1:0] nz;
      logic signed [NORM_W-1:0] ny;
      logic signed [NORM_W-1:0] nx;
   } plane_type;

   // Queue fill status seen by the front end
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[design/afc_front.sv]
// Front end: takes a box, orders each axis into low and high, hands it to the queue.
module afc_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_null,
   input  logic [6*COORD_WIDTH-1:0]   in_coords,
   input  afc_pkg::queue_status_type  q_status,
   output logic                       q_push,
   output logic [6*COORD_WIDTH:0]     q_wdata
);
   import afc_pkg::*;

   localparam int CW = COORD_WIDTH;

   logic                valid_ff, valid_in;
   logic [6*CW:0]       box_ff, box_in;
   logic                accept;

   assign q_push   = valid_ff && !q_status.full;
   assign in_ready = !valid_ff || !q_status.full;
   assign accept   = in_valid && in_ready;
   assign q_wdata  = box_ff;

   always_comb begin
      logic signed [CW-1:0] lo_v, hi_v;
      box_in       = box_ff;
      box_in[6*CW] = in_null;
      for (int a = 0; a < 3; a++) begin
         lo_v = in_coords[a*CW +: CW];
         hi_v = in_coords[(3+a)*CW +: CW];
         // Inverted boxes keep the same corner set, so just order the pair
         if (lo_v <= hi_v) begin
            box_in[a*CW +: CW]     = lo_v;
            box_in[(3+a)*CW +: CW] = hi_v;
         end else begin
            box_in[a*CW +: CW]     = hi_v;
            box_in[(3+a)*CW +: CW] = lo_v;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         box_ff <= box_in;
      end
   end

endmodule

[design/afc_queue.sv]
// Short register queue between the front end and the distance pipeline.
module afc_queue #(
   parameter int WIDTH = 97,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output afc_pkg::queue_status_type  status
);
   import afc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign status = '{full: (count_ff == CNT_W'(DEPTH)), empty: (count_ff == '0)};
   assign rdata  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from empty queue");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not advance on push");
`endif

endmodule

[design/afc_back.sv]
// Back end: plane distance pipeline, classification and the result register.
module afc_back #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                       clock,
   input  logic                       reset,
   input  afc_pkg::queue_status_type  q_status,
   input  logic [6*COORD_WIDTH:0]     q_rdata,
   output logic                       q_pop,
   input  afc_pkg::plane_type         planes [afc_pkg::PLANE_COUNT],
   input  logic                       far_infinite,
   output logic                       out_valid,
   input  logic                       out_ready,
   output afc_pkg::vis_type           out_vis
);
   import afc_pkg::*;

   localparam int CW     = COORD_WIDTH;
   localparam int FB     = NORMAL_FRAC_BITS;
   localparam int PROD_W = NORM_W + CW;
   localparam int SUM_W  = ((CW > FB) ? CW : FB) + NORM_W + 2;

   logic advance;

   // stage 1: per-axis extreme products
   logic                     v1_ff, v1_in;
   logic                     null1_ff;
   logic signed [PROD_W-1:0] pmin_ff [PLANE_COUNT][3];
   logic signed [PROD_W-1:0] pmax_ff [PLANE_COUNT][3];
   logic signed [PROD_W-1:0] pmin_in [PLANE_COUNT][3];
   logic signed [PROD_W-1:0] pmax_in [PLANE_COUNT][3];

   // stage 2: sign of nearest and farthest corner per plane
   logic                   v2_ff, v2_in;
   logic                   null2_ff;
   logic [PLANE_COUNT-1:0] neg_min_ff, neg_min_in;
   logic [PLANE_COUNT-1:0] neg_max_ff, neg_max_in;

   // result register
   logic    vo_ff, vo_in;
   vis_type vis_ff, vis_in;

   // The whole pipeline moves together whenever the result slot can take a transfer
   assign advance   = !vo_ff || out_ready;
   assign q_pop     = advance && !q_status.empty;
   assign out_valid = vo_ff;
   assign out_vis   = vis_ff;

   always_comb begin
      logic signed [NORM_W-1:0] n_v;
      logic signed [CW-1:0]     lo_v, hi_v;
      logic [4*NORM_W-1:0]      raw_v;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         raw_v = planes[p];
         for (int a = 0; a < 3; a++) begin
            n_v  = raw_v[a*NORM_W +: NORM_W];
            lo_v = q_rdata[a*CW +: CW];
            hi_v = q_rdata[(3+a)*CW +: CW];
            // Nonnegative normal: low end gives the minimum; negative flips it
            if (!n_v[NORM_W-1]) begin
               pmin_in[p][a] = n_v * lo_v;
               pmax_in[p][a] = n_v * hi_v;
            end else begin
               pmin_in[p][a] = n_v * hi_v;
               pmax_in[p][a] = n_v * lo_v;
            end
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0] dsc_v, smin_v, smax_v;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         dsc_v  = SUM_W'(planes[p].d) <<< FB;
         smin_v = dsc_v + SUM_W'(pmin_ff[p][0]) + SUM_W'(pmin_ff[p][1])
                  + SUM_W'(pmin_ff[p][2]);
         smax_v = dsc_v + SUM_W'(pmax_ff[p][0]) + SUM_W'(pmax_ff[p][1])
                  + SUM_W'(pmax_ff[p][2]);
         neg_min_in[p] = smin_v[SUM_W-1];
         neg_max_in[p] = smax_v[SUM_W-1];
      end
   end

   always_comb begin
      logic [PLANE_COUNT-1:0] use_v;
      use_v            = '1;
      use_v[FAR_INDEX] = !far_infinite;
      if (null2_ff || ((neg_max_ff & use_v) != '0)) begin
         vis_in = VIS_NONE;
      end else if ((neg_min_ff & use_v) != '0) begin
         vis_in = VIS_PARTIAL;
      end else begin
         vis_in = VIS_FULL;
      end
   end

   always_comb begin
      v1_in = advance ? !q_status.empty : v1_ff;
      v2_in = advance ? v1_ff : v2_ff;
      vo_in = advance ? v2_ff : vo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         null1_ff   <= q_rdata[6*CW];
         pmin_ff    <= pmin_in;
         pmax_ff    <= pmax_in;
         null2_ff   <= null1_ff;
         neg_min_ff <= neg_min_in;
         neg_max_ff <= neg_max_in;
         vis_ff     <= vis_in;
      end
   end

endmodule

[design/aabb_frustum_classifier.sv]
// An accepted box passes the front-end register, the queue, the product stage, the sign stage and the result register.
// Throughput: one box per cycle while rsp_tready holds; the multiply and plane-sum stages are fully pipelined.
// A 4-entry queue decouples the input stage from the distance pipeline and result register.
// Reset (synchronous, active high) empties the pipeline and queue, zeroes all six planes
// and clears far_infinite; no clearing pass, the block takes items right after reset.
module aabb_frustum_classifier #(
   parameter int COORD_WIDTH      = 16,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // min_x, min_y, min_z, max_x, max_y, max_z, zero padded to bytes
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // box_null
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // visibility, upper bits zero
   output logic [7:0]                            rsp_tdata,
   input  logic                                  csr_we,
   input  logic [afc_pkg::CSR_IDX_W-1:0]         csr_idx,
   input  logic [afc_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import afc_pkg::*;

   localparam int CW      = COORD_WIDTH;
   localparam int BOX_W   = 6 * CW + 1;
   localparam int Q_DEPTH = 4;

   plane_type        plane_ff [PLANE_COUNT];
   logic             far_inf_ff;
   queue_status_type q_status;
   logic             q_push, q_pop;
   logic [BOX_W-1:0] q_wdata, q_rdata;
   vis_type          vis;

   // Hold configuration; writes beyond the register list drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PLANE_COUNT; p++) begin
            plane_ff[p] <= '0;
         end
         far_inf_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_idx < CSR_IDX_W'(PLANE_COUNT)) begin
            plane_ff[csr_idx] <= csr_wdata;
         end else if (csr_idx == CSR_FAR_INFINITE) begin
            far_inf_ff <= csr_wdata[0];
         end
      end
   end

   afc_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_null   (req_tuser),
      .in_coords (req_tdata[6*CW-1:0]),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   afc_queue #(
      .WIDTH (BOX_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   afc_back #(
      .COORD_WIDTH      (COORD_WIDTH),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .q_rdata      (q_rdata),
      .q_pop        (q_pop),
      .planes       (plane_ff),
      .far_infinite (far_inf_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_vis      (vis)
   );

   assign rsp_tdata = {6'd0, vis};

endmodule
